// ===== hw/rtl/modexp_pkg.sv =====
package modexp_pkg;
    localparam int OpW  = 31;
    localparam int ExpW = 32;
    localparam int ExpCntW = $clog2(ExpW);

    typedef logic [OpW-1:0] t_opnd;
    typedef logic [OpW:0]   t_acc;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_BRED = 5'b00010,
        ST_SQR  = 5'b00100,
        ST_MUL  = 5'b01000,
        ST_OUT  = 5'b10000
    } t_state;
endpackage

// ===== hw/rtl/modexp_cell.sv =====
// One cell of the modular-multiply chain. Cells are chained so that a
// multiplier bit, MSB first, walks down the row, one cell per cycle. Each
// cell doubles the partial residue, adds the multiplicand when its bit is
// set and reduces, so the row computes a * b mod m.
module modexp_cell (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_vld,
    input  logic                    i_bit,
    input  modexp_pkg::t_opnd       i_acc,
    input  modexp_pkg::t_opnd       i_a,
    input  modexp_pkg::t_opnd       i_m,
    output logic                    o_vld,
    output modexp_pkg::t_opnd       o_acc
);
    modexp_pkg::t_acc dbl;
    modexp_pkg::t_acc red1;
    modexp_pkg::t_acc sum;
    modexp_pkg::t_opnd n_acc;
    modexp_pkg::t_opnd r_acc;
    logic r_vld;

    always_comb begin
        dbl  = {i_acc, 1'b0};
        red1 = (dbl >= {1'b0, i_m}) ? dbl - {1'b0, i_m} : dbl;
        sum  = i_bit ? red1 + {1'b0, i_a} : red1;
        n_acc = (sum >= {1'b0, i_m}) ? modexp_pkg::OpW'(sum - {1'b0, i_m})
                                     : modexp_pkg::OpW'(sum);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
        r_acc <= n_acc;
    end

    assign o_vld = r_vld;
    assign o_acc = r_acc;
endmodule

// ===== hw/rtl/modexp_mulchain.sv =====
// Row of OpW cells. Operand b is fed as a bit vector that shifts along
// with the data so each cell picks the next multiplier bit.
module modexp_mulchain (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  modexp_pkg::t_opnd       i_a,
    input  modexp_pkg::t_opnd       i_b,
    input  modexp_pkg::t_opnd       i_m,
    output logic                    o_done,
    output modexp_pkg::t_opnd       o_prod
);
    localparam int N = modexp_pkg::OpW;
    logic              vld [N+1];
    modexp_pkg::t_opnd acc [N+1];
    modexp_pkg::t_opnd r_b [N+1];

    assign vld[0] = i_start;
    assign acc[0] = '0;
    assign r_b[0] = i_b;

    for (genvar g = 0; g < N; g++) begin : g_cell
        modexp_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_vld  (vld[g]),
            .i_bit  (r_b[g][N-1-g]),
            .i_acc  (acc[g]),
            .i_a    (i_a),
            .i_m    (i_m),
            .o_vld  (vld[g+1]),
            .o_acc  (acc[g+1])
        );
        modexp_pkg::t_opnd r_bs;
        always_ff @(posedge i_clk) begin
            r_bs <= r_b[g];
        end
        assign r_b[g+1] = r_bs;
    end

    assign o_done = vld[N];
    assign o_prod = acc[N];
endmodule

// ===== hw/rtl/modular_exponentiation.sv =====
// Channel  Dir  tdata fields (LSB first)                     tuser
// s_axis   in   base[30:0], exponent[62:31], modulus[93:63]  -
// m_axis   out  power_residue[30:0]                         zero_modulus
//
// One item at a time. The base is reduced first (one chain pass), then each
// of the 32 exponent bits takes a square and, when set, a multiply; every
// modular multiply is a pass down the cell row, then a restart. Reset is
// synchronous, active low. A result held on m_axis waits for tready;
// s_axis is ready only when idle.
module modular_exponentiation (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [95:0]  s_axis_tdata,  // base, exponent, modulus
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [31:0]  m_axis_tdata,  // power_residue
    output logic         m_axis_tuser   // zero_modulus
);
    localparam int OpW  = modexp_pkg::OpW;
    localparam int ExpW = modexp_pkg::ExpW;

    modexp_pkg::t_state r_state;
    modexp_pkg::t_opnd  r_base, r_mod, r_res;
    logic [ExpW-1:0]    r_exp;
    logic [modexp_pkg::ExpCntW-1:0] r_cnt;
    logic               r_zero, r_go;
    modexp_pkg::t_opnd  mul_a, mul_b, prod;
    logic               done;

    // The base may exceed the modulus while the chain needs a < m, so during
    // reduction the base enters as the multiplier bits against a = 1.
    always_comb begin
        mul_a = r_res;
        mul_b = r_res;
        case (r_state)
            modexp_pkg::ST_BRED: begin
                mul_a = modexp_pkg::t_opnd'(1);
                mul_b = r_base;
            end
            modexp_pkg::ST_MUL: mul_b = r_base;
            default: ;
        endcase
    end

    modexp_mulchain u_chain (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(r_go),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .i_m    (r_mod),
        .o_done (done),
        .o_prod (prod)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= modexp_pkg::ST_IDLE;
            r_go    <= 1'b0;
        end else begin
            r_go <= 1'b0;
            unique case (r_state)
                modexp_pkg::ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_base <= s_axis_tdata[OpW-1:0];
                        r_exp  <= s_axis_tdata[OpW+ExpW-1:OpW];
                        r_mod  <= s_axis_tdata[2*OpW+ExpW-1:OpW+ExpW];
                        r_zero <= (s_axis_tdata[2*OpW+ExpW-1:OpW+ExpW] == '0);
                        r_cnt  <= '0;
                        if (s_axis_tdata[2*OpW+ExpW-1:OpW+ExpW] == '0) begin
                            r_res   <= '0;
                            r_state <= modexp_pkg::ST_OUT;
                        end else begin
                            r_go    <= 1'b1;
                            r_state <= modexp_pkg::ST_BRED;
                        end
                    end
                end
                modexp_pkg::ST_BRED: begin
                    if (done) begin
                        r_base  <= prod;
                        r_res   <= (r_mod == modexp_pkg::t_opnd'(1)) ? '0
                                   : modexp_pkg::t_opnd'(1);
                        r_go    <= 1'b1;
                        r_state <= modexp_pkg::ST_SQR;
                    end
                end
                modexp_pkg::ST_SQR: begin
                    if (done) begin
                        r_res <= prod;
                        r_go  <= 1'b1;
                        if (r_exp[ExpW-1]) begin
                            r_state <= modexp_pkg::ST_MUL;
                        end else if (r_cnt == modexp_pkg::ExpCntW'(ExpW - 1)) begin
                            r_go    <= 1'b0;
                            r_state <= modexp_pkg::ST_OUT;
                        end else begin
                            r_exp <= r_exp << 1;
                            r_cnt <= r_cnt + 1'b1;
                        end
                    end
                end
                modexp_pkg::ST_MUL: begin
                    if (done) begin
                        r_res <= prod;
                        r_exp <= r_exp << 1;
                        r_cnt <= r_cnt + 1'b1;
                        if (r_cnt == modexp_pkg::ExpCntW'(ExpW - 1)) begin
                            r_state <= modexp_pkg::ST_OUT;
                        end else begin
                            r_go    <= 1'b1;
                            r_state <= modexp_pkg::ST_SQR;
                        end
                    end
                end
                modexp_pkg::ST_OUT: begin
                    if (m_axis_tready) r_state <= modexp_pkg::ST_IDLE;
                end
                default: r_state <= modexp_pkg::ST_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == modexp_pkg::ST_IDLE);
    assign m_axis_tvalid = (r_state == modexp_pkg::ST_OUT);
    assign m_axis_tdata  = {1'b0, r_res};
    assign m_axis_tuser  = r_zero;
endmodule

// ===== verif/modular_exponentiation_tb.sv =====
`timescale 1ns / 1ps

module modular_exponentiation_tb;
    typedef struct packed {
        logic [modexp_pkg::OpW-1:0]  modulus;
        logic [modexp_pkg::ExpW-1:0] exponent;
        logic [modexp_pkg::OpW-1:0]  base;
    } t_job;

    typedef struct {
        logic [modexp_pkg::OpW-1:0] residue;
        logic                       zero_mod;
    } t_residue;

    localparam int ItemLatency = 33 + 32 * 64 + 50;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata;   // base, exponent, modulus
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // power_residue
    logic        m_axis_tuser;   // zero_modulus

    t_job     pending_jobs[$];
    t_residue expected_residues[$];
    int       error_count = 0;
    int       results_seen = 0;
    int       zero_mod_seen = 0;
    bit       calm = 0;           // no random idling while set
    bit       hold_start = 0;     // starts a long receiver stall
    int       hold_cnt = 0;       // receiver stall cycles left

    modular_exponentiation dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    function automatic t_residue modexp_predict(t_job j);
        t_residue r;
        logic [63:0] m, b, acc;
        m = 64'(j.modulus);
        r.zero_mod = (m == 0);
        r.residue = '0;
        if (m != 0) begin
            b = 64'(j.base) % m;
            acc = 64'd1 % m;
            for (int i = modexp_pkg::ExpW - 1; i >= 0; i--) begin
                acc = (acc * acc) % m;
                if (j.exponent[i]) acc = (acc * b) % m;
            end
            r.residue = acc[modexp_pkg::OpW-1:0];
        end
        return r;
    endfunction

    function automatic t_job make_job(logic [modexp_pkg::OpW-1:0] b,
                                      logic [modexp_pkg::ExpW-1:0] e,
                                      logic [modexp_pkg::OpW-1:0] m);
        t_job j;
        j.base = b;
        j.exponent = e;
        j.modulus = m;
        return j;
    endfunction

    task automatic queue_job(t_job j);
        pending_jobs.insert(pending_jobs.size(), j);
    endtask

    function automatic logic [modexp_pkg::OpW-1:0] rand_operand();
        case ($urandom_range(0, 5))
            0: return modexp_pkg::OpW'($urandom_range(0, 15));
            1: return {modexp_pkg::OpW{1'b1}} - modexp_pkg::OpW'($urandom_range(0, 3));
            2: return modexp_pkg::OpW'($urandom_range(0, 65535));
            default: return modexp_pkg::OpW'($urandom);
        endcase
    endfunction

    // Driver: the sender offers the head of the queue, idling at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (s_axis_tvalid) begin
                expected_residues.insert(expected_residues.size(),
                                         modexp_predict(t_job'(s_axis_tdata[93:0])));
                void'(pending_jobs.pop_front());
            end
            if (pending_jobs.size() > 0 &&
                (calm || $urandom_range(0, 99) >= 20)) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {2'b00, pending_jobs[0]};
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Long receiver stall, counted in cycles.
    always @(posedge i_clk) begin
        if (hold_start) begin
            hold_cnt <= 3 * ItemLatency;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
        end
    end

    // Monitor: the receiver stalls at random and compares each transfer.
    always @(posedge i_clk) begin
        t_residue exp_r;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                if (m_axis_tuser) zero_mod_seen++;
                if (expected_residues.size() == 0) begin
                    $error("result with no expectation: residue %0d", m_axis_tdata);
                    error_count++;
                end else begin
                    exp_r = expected_residues.pop_front();
                    if (m_axis_tdata !== {1'b0, exp_r.residue}) begin
                        $error("power_residue: expected %0d, got %0d",
                               exp_r.residue, m_axis_tdata);
                        error_count++;
                    end
                    if (m_axis_tuser !== exp_r.zero_mod) begin
                        $error("zero_modulus: expected %0d, got %0d",
                               exp_r.zero_mod, m_axis_tuser);
                        error_count++;
                    end
                end
            end
            if (hold_cnt > 0) begin
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= calm || $urandom_range(0, 99) >= 20;
            end
        end
    end

    task automatic wait_drained();
        while (pending_jobs.size() != 0 || s_axis_tvalid || expected_residues.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        logic [modexp_pkg::OpW-1:0] all_ones;
        all_ones = {modexp_pkg::OpW{1'b1}};
        i_rst_n = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed corners: zero modulus, zero exponent, modulus of one,
        // all-ones fields and small known powers.
        queue_job(make_job(31'd5, 32'd3, 31'd0));
        queue_job(make_job(all_ones, '1, 31'd0));
        queue_job(make_job(31'd7, 32'd0, 31'd13));
        queue_job(make_job(31'd0, 32'd0, 31'd13));
        queue_job(make_job(31'd0, 32'd0, 31'd1));
        queue_job(make_job(31'd12345, 32'd77, 31'd1));
        queue_job(make_job(31'd2, 32'd10, 31'd1000));
        queue_job(make_job(31'd3, 32'd200, 31'd7));
        queue_job(make_job(all_ones, '1, all_ones));
        queue_job(make_job(all_ones, '1, all_ones - 31'd1));
        queue_job(make_job(all_ones - 31'd1, 32'h8000_0000, all_ones));
        queue_job(make_job(31'd0, 32'd5, 31'd97));
        queue_job(make_job(31'd1, '1, 31'd2));
        queue_job(make_job(31'd100, 32'd1, 31'd7));
        queue_job(make_job(31'd2, 32'h5555_5555, 31'h7FFF_FFED));
        queue_job(make_job(31'h2AAA_AAAA, 32'hAAAA_AAAA, 31'h5555_5555));
        wait_drained();

        // Receiver stalls long while the sender keeps offering.
        hold_start <= 1'b1;
        @(posedge i_clk);
        hold_start <= 1'b0;
        for (int i = 0; i < 4; i++)
            queue_job(make_job(rand_operand(), $urandom, rand_operand()));
        wait_drained();

        for (int i = 0; i < 250; i++) begin
            if (i == 100) begin
                wait_drained();
                calm = 1;
            end
            if (i == 140) begin
                wait_drained();
                calm = 0;
            end
            queue_job(make_job(rand_operand(),
                ($urandom_range(0, 4) == 0) ? 32'($urandom_range(0, 255)) : 32'($urandom),
                ($urandom_range(0, 19) == 0) ? modexp_pkg::OpW'(0) : rand_operand()));
            if (i % 20 == 19) @(posedge i_clk);
        end
        wait_drained();
        repeat (ItemLatency) @(posedge i_clk);
        if (expected_residues.size() != 0) begin
            $error("%0d expected results never arrived", expected_residues.size());
            error_count++;
        end
        $display("Covered %0d exponentiations, %0d with a zero modulus, including",
                 results_seen, zero_mod_seen);
        $display("zero exponents, unit moduli, all-ones fields and long output stalls.");
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #(64'd12 * 300 * ItemLatency * 5);
        $display("Test completed with failures");
        $finish;
    end
endmodule
